// ===== rtl/core/aids_pkg.sv =====
// Shared types, codes and constants for the positional word store core.
// Used by every module under rtl/core except aids_ram; depends on nothing else.
package aids_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned IDX_W        = 6;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_SEARCH   = 2'd2,
    ACT_TRAVERSE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BADPOS = 3'd1,
    ST_FULL   = 3'd2,
    ST_MISS   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef struct packed {
    action_e                   action;
    logic signed [DATA_W-1:0]  value;
    logic        [POS_W-1:0]   position;
  } in_word_t;

  typedef struct packed {
    status_e                   status;
    logic        [IDX_W-1:0]   index;
    logic signed [DATA_W-1:0]  word;
    logic                      last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_TRAV_RD,
    S_TRAV_EMIT,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_COUNT,
    PTR_POS,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_DEC,
    RD_PTR_INC
  } rd_sel_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_RESP,
    OUT_TRAV
  } out_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    ptr_op_e ptr_op;
    cnt_op_e cnt_op;
    logic    ram_rd;
    rd_sel_e rd_sel;
    logic    ram_wr;
    logic    wr_value;
    logic    set_status;
    status_e status;
    out_op_e out_op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    pos_gt_count;
    logic    pos_ge_count;
    logic    full;
    logic    empty;
    logic    ptr_gt_pos;
    logic    del_more;
    logic    scan_done;
    logic    trav_last;
    logic    match;
    logic    out_free;
  } stat_t;

endpackage

// ===== rtl/core/aids_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
module aids_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    // Read data holds until the next read.
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/aids_ctrl.sv =====
// Controller state machine for the positional word store core.
// Depends on aids_pkg for the state, command and status types.
module aids_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  aids_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output aids_pkg::cmd_t  cmd_o
);
  import aids_pkg::*;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat_i.action)
          ACT_INSERT: begin
            state_d = (stat_i.pos_gt_count || stat_i.full) ? S_RESP : S_INS_RD;
          end
          ACT_DELETE: begin
            state_d = stat_i.pos_ge_count ? S_RESP : S_DEL_RD;
          end
          ACT_SEARCH: begin
            state_d = S_SRCH_RD;
          end
          ACT_TRAVERSE: begin
            state_d = stat_i.empty ? S_RESP : S_TRAV_RD;
          end
        endcase
      end
      S_INS_RD: begin
        state_d = stat_i.ptr_gt_pos ? S_INS_WR : S_RESP;
      end
      S_INS_WR: begin
        state_d = S_INS_RD;
      end
      S_DEL_RD: begin
        state_d = stat_i.del_more ? S_DEL_WR : S_RESP;
      end
      S_DEL_WR: begin
        state_d = S_DEL_RD;
      end
      S_SRCH_RD: begin
        state_d = stat_i.scan_done ? S_RESP : S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        state_d = stat_i.match ? S_RESP : S_SRCH_RD;
      end
      S_TRAV_RD: begin
        state_d = S_TRAV_EMIT;
      end
      S_TRAV_EMIT: begin
        if (stat_i.out_free) begin
          state_d = stat_i.trav_last ? S_IDLE : S_TRAV_RD;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd            = '0;
    cmd.ptr_op     = PTR_HOLD;
    cmd.cnt_op     = CNT_HOLD;
    cmd.rd_sel     = RD_PTR;
    cmd.status     = ST_OK;
    cmd.out_op     = OUT_NONE;
    unique case (state_q)
      S_IDLE: begin
        cmd.accept = 1'b1;
      end
      S_DECODE: begin
        unique case (stat_i.action)
          ACT_INSERT: begin
            if (stat_i.pos_gt_count) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
            end else if (stat_i.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.ptr_op = PTR_COUNT;
            end
          end
          ACT_DELETE: begin
            if (stat_i.pos_ge_count) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
            end else begin
              cmd.ptr_op = PTR_POS;
            end
          end
          ACT_SEARCH: begin
            cmd.ptr_op = PTR_ZERO;
          end
          ACT_TRAVERSE: begin
            if (stat_i.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.ptr_op = PTR_ZERO;
            end
          end
        endcase
      end
      S_INS_RD: begin
        if (stat_i.ptr_gt_pos) begin
          cmd.ram_rd = 1'b1;
          cmd.rd_sel = RD_PTR_DEC;
        end else begin
          cmd.ram_wr     = 1'b1;
          cmd.wr_value   = 1'b1;
          cmd.cnt_op     = CNT_INC;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
        end
      end
      S_INS_WR: begin
        cmd.ram_wr = 1'b1;
        cmd.ptr_op = PTR_DEC;
      end
      S_DEL_RD: begin
        if (stat_i.del_more) begin
          cmd.ram_rd = 1'b1;
          cmd.rd_sel = RD_PTR_INC;
        end else begin
          cmd.cnt_op     = CNT_DEC;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
        end
      end
      S_DEL_WR: begin
        cmd.ram_wr = 1'b1;
        cmd.ptr_op = PTR_INC;
      end
      S_SRCH_RD: begin
        if (stat_i.scan_done) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_MISS;
        end else begin
          cmd.ram_rd = 1'b1;
        end
      end
      S_SRCH_CMP: begin
        if (stat_i.match) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_TRAV_RD: begin
        cmd.ram_rd = 1'b1;
      end
      S_TRAV_EMIT: begin
        if (stat_i.out_free) begin
          cmd.out_op = OUT_TRAV;
          if (!stat_i.trav_last) cmd.ptr_op = PTR_INC;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) cmd.out_op = OUT_RESP;
      end
      default: begin
        cmd.accept = 1'b0;
      end
    endcase
  end

  assign cmd_o      = cmd;
  assign in_ready_o = cmd.accept;

  // A count update always closes the operation with its single response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.cnt_op != CNT_HOLD) |=> (state_q == S_RESP))
    else $error("count changed without moving to the response state");

  // An accepted word is always decoded on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted word was not decoded");

  // Result words are loaded only from the emit and response states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_op != OUT_NONE) |-> (state_q == S_TRAV_EMIT || state_q == S_RESP))
    else $error("result word loaded outside an emit or response state");

endmodule

// ===== rtl/core/aids_dp.sv =====
// Datapath for the positional word store: request latch, pointer, count,
// entry RAM and output register. Depends on aids_pkg and aids_ram.
module aids_dp #(
  parameter int unsigned CAPACITY = aids_pkg::DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  aids_pkg::in_word_t  in_word_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output aids_pkg::out_word_t out_word_o,
  input  aids_pkg::cmd_t      cmd_i,
  output aids_pkg::stat_t     stat_o
);
  import aids_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  in_word_t         req_q;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    count_q, count_d;
  status_e          res_status_q;
  logic             out_valid_q;
  out_word_t        out_q, out_d;

  logic [CW-1:0]    ptr_inc, ptr_dec;
  logic [AW-1:0]    rd_addr;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] rd_data;
  logic             out_free;
  logic             trav_last;

  assign ptr_inc   = ptr_q + CW'(1);
  assign ptr_dec   = ptr_q - CW'(1);
  assign out_free  = !out_valid_q || out_ready_i;
  assign trav_last = (ptr_inc == count_q);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PTR_DEC: rd_addr = ptr_dec[AW-1:0];
      RD_PTR_INC: rd_addr = ptr_inc[AW-1:0];
      default:    rd_addr = ptr_q[AW-1:0];
    endcase
  end

  assign wr_data = cmd_i.wr_value ? req_q.value : rd_data;

  aids_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.ram_wr),
    .wr_addr_i(ptr_q[AW-1:0]),
    .wr_data_i(wr_data),
    .rd_en_i  (cmd_i.ram_rd),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    case (cmd_i.ptr_op)
      PTR_ZERO:  ptr_d = '0;
      PTR_COUNT: ptr_d = count_q;
      PTR_POS:   ptr_d = CW'(req_q.position);
      PTR_INC:   ptr_d = ptr_inc;
      PTR_DEC:   ptr_d = ptr_dec;
      default:   ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + CW'(1);
      CNT_DEC: count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_comb begin
    out_d = out_q;
    case (cmd_i.out_op)
      OUT_RESP: begin
        out_d.status = res_status_q;
        out_d.index  = (req_q.action == ACT_SEARCH && res_status_q == ST_OK) ?
                       IDX_W'(ptr_q) : '0;
        out_d.word   = '0;
        out_d.last   = 1'b1;
      end
      OUT_TRAV: begin
        out_d.status = ST_OK;
        out_d.index  = IDX_W'(ptr_q);
        out_d.word   = rd_data;
        out_d.last   = trav_last;
      end
      default: begin
        out_d = out_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q   <= ptr_d;
      count_q <= count_d;
      if (cmd_i.out_op != OUT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_valid_i) begin
      req_q <= in_word_i;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
    end
    out_q <= out_d;
  end

  always_comb begin
    stat_o              = '0;
    stat_o.action       = req_q.action;
    stat_o.pos_gt_count = req_q.position > POS_W'(count_q);
    stat_o.pos_ge_count = req_q.position >= POS_W'(count_q);
    stat_o.full         = (count_q == CW'(CAPACITY));
    stat_o.empty        = (count_q == '0);
    stat_o.ptr_gt_pos   = POS_W'(ptr_q) > req_q.position;
    stat_o.del_more     = (ptr_inc < count_q);
    stat_o.scan_done    = (ptr_q == count_q);
    stat_o.trav_last    = trav_last;
    stat_o.match        = (rd_data == req_q.value);
    stat_o.out_free     = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // The count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Every RAM write lands inside the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ram_wr |-> (ptr_q < CW'(CAPACITY)))
    else $error("RAM write beyond capacity");

  // The output register is loaded only when its word is gone or leaving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_op != OUT_NONE) |-> out_free)
    else $error("output word overwritten before it was taken");

endmodule

// ===== rtl/core/array_insert_delete_search_core.sv =====
// Top level of the positional word store core: controller plus datapath.
// Depends on aids_pkg, aids_ctrl, aids_dp (and aids_ram through aids_dp).
//
// The core holds up to CAPACITY signed 32-bit words in positional order.
// An input word on the in_valid_i/in_ready_o channel carries an action
// (insert, delete, search, traverse), a value and a position. Result words
// leave on out_valid_o/out_ready_i; each carries a status, an index, a data
// word and a last flag that marks the final result of one input word.
// Insert, delete and search give one result word; traverse gives one
// result word per stored entry, or a single empty status.
//
// The core works on one input word at a time; in_ready_o is high only while
// it is idle. Every entry that an operation touches costs a read through the
// single read port of the entry RAM, then a write through its single write
// port, a compare or an emit. An insert at position p moves each entry from p
// up by one place, a delete moves each entry above p down by one place, a
// search reads entries from index 0 until a hit or the count, and a traverse
// reads every stored entry in order.
//
// Reset clears the entry count and the valid flag of the output register;
// the entry RAM needs no clearing since only entries below the count are
// read. When the receiver stalls, the result word waits in the output
// register and the controller holds its place until that register frees up;
// a new input word is taken while the last result of the previous one waits.
module array_insert_delete_search_core #(
  parameter int unsigned CAPACITY = aids_pkg::DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aids_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aids_pkg::out_word_t out_word_o
);
  import aids_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  aids_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .stat_i    (stat),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd)
  );

  aids_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule
